// File: rtl/core/u64df_pkg.sv
// ============================================================================
// u64df_pkg
// Shared constants, types and state encodings of the 64-bit decimal formatter.
// ============================================================================
`default_nettype none

package u64df_pkg;

    localparam int VALUE_W       = 64;
    localparam int SIZE_W        = 8;
    localparam int MAX_DIGITS    = 20;
    localparam int BCD_DIGITS    = 20;
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam int COUNT_W       = 5;
    localparam int CHAR_W        = 6;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
    localparam int IN_DATA_W     = VALUE_W + SIZE_W;
    localparam int OUT_DATA_W    = 16;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic {
        C_IDLE,
        C_RUN
    } t_conv_state;

    typedef enum logic [1:0] {
        E_IDLE,
        E_STRIP,
        E_EMIT
    } t_emit_state;

    typedef struct packed {
        logic               valid;
        logic [BCD_W-1:0]   bcd;
        logic [COUNT_W-1:0] limit;
    } t_bcd_res;

endpackage

`default_nettype wire

// File: rtl/core/u64df_bcd_conv.sv
// ============================================================================
// u64df_bcd_conv
// Shift-and-add-three converter that turns the binary value into twenty BCD
// digits, four bits of the value per cycle, and works out the digit limit.
// ============================================================================
`default_nettype none

module u64df_bcd_conv (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [u64df_pkg::VALUE_W-1:0]   i_value,
    input  wire logic [u64df_pkg::SIZE_W-1:0]    i_buffer_size,
    output logic                                 o_idle,
    output u64df_pkg::t_bcd_res                  o_res
);

    localparam int VW = u64df_pkg::VALUE_W;
    localparam int BW = u64df_pkg::BCD_W;
    localparam int CW = u64df_pkg::COUNT_W;
    localparam int SW = u64df_pkg::STEP_CNT_W;

    u64df_pkg::t_conv_state r_state, n_state;
    logic [VW-1:0]          r_bin, n_bin;
    logic [BW-1:0]          r_bcd, n_bcd;
    logic [SW-1:0]          r_cnt, n_cnt;
    logic [CW-1:0]          r_limit, n_limit;
    logic                   r_done, n_done;
    logic [VW+BW-1:0]       w_stepped;

    function automatic logic [VW+BW-1:0] dabble(input logic [VW+BW-1:0] acc);
        logic [VW+BW-1:0] a;
        a = acc;
        for (int s = 0; s < u64df_pkg::BITS_PER_STEP; s++) begin
            for (int d = 0; d < u64df_pkg::BCD_DIGITS; d++) begin
                if (a[VW+4*d +: 4] >= 4'd5) begin
                    a[VW+4*d +: 4] = a[VW+4*d +: 4] + 4'd3;
                end
            end
            a = {a[VW+BW-2:0], 1'b0};
        end
        return a;
    endfunction

    function automatic logic [CW-1:0] digit_limit(input logic [u64df_pkg::SIZE_W-1:0] sz);
        logic [u64df_pkg::SIZE_W-1:0] m;
        logic [CW-1:0]                lim;
        m = sz - 8'd1;
        if (sz < 8'd2) begin
            lim = CW'(1);
        end else if (m > 8'(u64df_pkg::MAX_DIGITS)) begin
            lim = CW'(u64df_pkg::MAX_DIGITS);
        end else begin
            lim = m[CW-1:0];
        end
        return lim;
    endfunction

    assign w_stepped = dabble({r_bcd, r_bin});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            u64df_pkg::C_IDLE: begin
                if (i_start) begin
                    n_state = u64df_pkg::C_RUN;
                end
            end
            u64df_pkg::C_RUN: begin
                if (r_cnt == SW'(u64df_pkg::CONV_STEPS - 1)) begin
                    n_state = u64df_pkg::C_IDLE;
                end
            end
            default: n_state = u64df_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_limit = r_limit;
        n_done  = 1'b0;
        unique case (r_state)
            u64df_pkg::C_IDLE: begin
                if (i_start) begin
                    n_bin   = i_value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_limit = digit_limit(i_buffer_size);
                end
            end
            u64df_pkg::C_RUN: begin
                n_bin = w_stepped[VW-1:0];
                n_bcd = w_stepped[VW+BW-1:VW];
                n_cnt = r_cnt + SW'(1);
                if (r_cnt == SW'(u64df_pkg::CONV_STEPS - 1)) begin
                    n_done = 1'b1;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u64df_pkg::C_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_limit <= n_limit;
    end

    assign o_idle      = (r_state == u64df_pkg::C_IDLE) && !r_done;
    assign o_res.valid = r_done;
    assign o_res.bcd   = r_bcd;
    assign o_res.limit = r_limit;

endmodule

`default_nettype wire

// File: rtl/core/u64df_digit_emit.sv
// ============================================================================
// u64df_digit_emit
// Drops leading zeros and digits beyond the limit one digit per cycle, then
// shifts the kept digits out most significant first into the output register.
// ============================================================================
`default_nettype none

module u64df_digit_emit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire u64df_pkg::t_bcd_res               i_res,
    output logic                                   o_idle,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [u64df_pkg::CHAR_W-1:0]           o_digit_char,
    output logic [u64df_pkg::COUNT_W-1:0]          o_digit_position,
    output logic                                   o_last,
    output logic                                   o_complete,
    output logic [u64df_pkg::COUNT_W-1:0]          o_digit_count
);

    localparam int BW = u64df_pkg::BCD_W;
    localparam int CW = u64df_pkg::COUNT_W;

    u64df_pkg::t_emit_state r_state, n_state;
    logic [BW-1:0]          r_bcd, n_bcd;
    logic [CW-1:0]          r_remain, n_remain;
    logic [CW-1:0]          r_limit, n_limit;
    logic [CW-1:0]          r_pos, n_pos;
    logic                   r_trunc, n_trunc;
    logic                   r_out_valid, n_out_valid;
    logic [u64df_pkg::CHAR_W-1:0] r_char, n_char;
    logic [CW-1:0]          r_out_pos, n_out_pos;
    logic                   r_last, n_last;
    logic                   r_complete, n_complete;
    logic [CW-1:0]          r_count, n_count;
    logic [3:0]             w_top;
    logic                   w_strip;
    logic                   w_slot;
    logic                   w_final;

    // Zeros in the kept window are only leading zeros if no nonzero digit was cut above it.
    assign w_top   = r_bcd[BW-1 -: 4];
    assign w_strip = (r_remain > r_limit) ||
                     (!r_trunc && (w_top == 4'd0) && (r_remain > CW'(1)));
    assign w_slot  = !r_out_valid || i_ready;
    assign w_final = (r_remain == CW'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            u64df_pkg::E_IDLE: begin
                if (i_res.valid) begin
                    n_state = u64df_pkg::E_STRIP;
                end
            end
            u64df_pkg::E_STRIP: begin
                if (!w_strip) begin
                    n_state = u64df_pkg::E_EMIT;
                end
            end
            u64df_pkg::E_EMIT: begin
                if (w_slot && w_final) begin
                    n_state = u64df_pkg::E_IDLE;
                end
            end
            default: n_state = u64df_pkg::E_IDLE;
        endcase
    end

    always_comb begin
        n_bcd       = r_bcd;
        n_remain    = r_remain;
        n_limit     = r_limit;
        n_pos       = r_pos;
        n_trunc     = r_trunc;
        n_out_valid = r_out_valid && !i_ready;
        n_char      = r_char;
        n_out_pos   = r_out_pos;
        n_last      = r_last;
        n_complete  = r_complete;
        n_count     = r_count;
        unique case (r_state)
            u64df_pkg::E_IDLE: begin
                if (i_res.valid) begin
                    n_bcd    = i_res.bcd;
                    n_remain = CW'(u64df_pkg::BCD_DIGITS);
                    n_limit  = i_res.limit;
                    n_pos    = '0;
                    n_trunc  = 1'b0;
                end
            end
            u64df_pkg::E_STRIP: begin
                if (w_strip) begin
                    n_bcd    = {r_bcd[BW-5:0], 4'd0};
                    n_remain = r_remain - CW'(1);
                    if ((r_remain > r_limit) && (w_top != 4'd0)) begin
                        n_trunc = 1'b1;
                    end
                end
            end
            u64df_pkg::E_EMIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = u64df_pkg::ASCII_ZERO + {2'b00, w_top};
                    n_out_pos   = r_pos;
                    n_last      = w_final;
                    n_complete  = w_final && !r_trunc;
                    n_count     = w_final ? (r_pos + CW'(1)) : '0;
                    n_bcd       = {r_bcd[BW-5:0], 4'd0};
                    n_remain    = r_remain - CW'(1);
                    n_pos       = r_pos + CW'(1);
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= u64df_pkg::E_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd      <= n_bcd;
        r_remain   <= n_remain;
        r_limit    <= n_limit;
        r_pos      <= n_pos;
        r_trunc    <= n_trunc;
        r_char     <= n_char;
        r_out_pos  <= n_out_pos;
        r_last     <= n_last;
        r_complete <= n_complete;
        r_count    <= n_count;
    end

    assign o_idle           = (r_state == u64df_pkg::E_IDLE);
    assign o_valid          = r_out_valid;
    assign o_digit_char     = r_char;
    assign o_digit_position = r_out_pos;
    assign o_last           = r_last;
    assign o_complete       = r_complete;
    assign o_digit_count    = r_count;

endmodule

`default_nettype wire

// File: rtl/core/u64_decimal_formatter_top.sv
// ============================================================================
// u64_decimal_formatter_top
// Formats a 64-bit unsigned value as decimal ASCII digits, one digit a word.
// ============================================================================
// The input stream carries one value and the size of the destination buffer
// per word. The output stream gives the kept digits most significant first,
// one digit per word, with tlast on the final digit; that word also carries
// the digit count and, in tuser, whether the whole value fitted.
// The digit limit is buffer size minus one, kept between one and twenty.
// One word is converted at a time. The converter works on four bits of
// the value per cycle, then hands its result to the emitter. The strip
// drops digits one at a time, then the kept digits are loaded one at a
// time; dropped and kept digits add up to twenty. A stalled receiver holds
// the current digit in the output register and pauses the digit shifter;
// the input side stays not ready until the last digit has been loaded.
// Reset empties the output register and returns both units to idle.
// ============================================================================
`default_nettype none

module u64_decimal_formatter_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // value [63:0], buffer_size [71:64]
    input  wire logic [u64df_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // digit_char [5:0], digit_position [10:6], digit_count [15:11]
    output logic [u64df_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    output logic                                      o_m_axis_tlast,
    // complete [0]
    output logic [0:0]                                o_m_axis_tuser
);

    logic                                  w_conv_idle;
    logic                                  w_emit_idle;
    logic                                  w_start;
    u64df_pkg::t_bcd_res                   w_res;
    logic [u64df_pkg::CHAR_W-1:0]          w_char;
    logic [u64df_pkg::COUNT_W-1:0]         w_pos;
    logic [u64df_pkg::COUNT_W-1:0]         w_count;
    logic                                  w_complete;

    assign o_s_axis_tready = w_conv_idle && w_emit_idle;
    assign w_start         = i_s_axis_tvalid && o_s_axis_tready;

    u64df_bcd_conv u_conv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_value       (i_s_axis_tdata[u64df_pkg::VALUE_W-1:0]),
        .i_buffer_size (i_s_axis_tdata[u64df_pkg::IN_DATA_W-1:u64df_pkg::VALUE_W]),
        .o_idle        (w_conv_idle),
        .o_res         (w_res)
    );

    u64df_digit_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_res            (w_res),
        .o_idle           (w_emit_idle),
        .o_valid          (o_m_axis_tvalid),
        .i_ready          (i_m_axis_tready),
        .o_digit_char     (w_char),
        .o_digit_position (w_pos),
        .o_last           (o_m_axis_tlast),
        .o_complete       (w_complete),
        .o_digit_count    (w_count)
    );

    assign o_m_axis_tdata = {w_count, w_pos, w_char};
    assign o_m_axis_tuser = w_complete;

endmodule

`default_nettype wire
